// ===== rtl/core/stick_to_wheel_rpm_mixer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Stick mixer assertion macros
// Shared concurrent assertion forms for the stick mixer checker.
// ----------------------------------------------------------------------------
`ifndef STICK_TO_WHEEL_RPM_MIXER_CORE_DEFINES_SVH
`define STICK_TO_WHEEL_RPM_MIXER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define STWRM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stwrm: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define STWRM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stwrm: next-cycle check failed");

`endif

// ===== rtl/core/stwrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stick mixer package
// Field widths, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package stwrm_pkg;

  // Port field widths
  localparam int unsigned STICK_W   = 12;
  localparam int unsigned SPEED_W   = 10;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 3;

  // Default fraction bits of the wheel speed outputs
  localparam int unsigned SPEED_FRAC_BITS_DEF = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_DIR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SKID_DIR     = 3'd6;

  // Register reset values
  localparam logic [STICK_W-1:0] DEAD_LOW_RST  = 12'd1450;
  localparam logic [STICK_W-1:0] DEAD_HIGH_RST = 12'd1550;
  localparam logic [STICK_W-1:0] STICK_MIN_RST = 12'd1000;
  localparam logic [STICK_W-1:0] STICK_MAX_RST = 12'd2000;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 10'd144;

  // Front-end arithmetic width (signed, holds every stick difference)
  localparam int unsigned ARITH_W = STICK_W + 4;

  // Signed factor widths and their magnitude widths
  localparam int unsigned TF_W   = 15;  // travel factor, |x| <= 12285
  localparam int unsigned DA_W   = 14;  // lane A divisor, |x| <= 8190
  localparam int unsigned D2F_W  = 14;  // steering span, |x| <= 4096
  localparam int unsigned E2_W   = 15;  // steering factor, |x| <= 8192
  localparam int unsigned TFM_W  = TF_W - 1;
  localparam int unsigned DAM_W  = DA_W - 1;
  localparam int unsigned D2M_W  = D2F_W - 1;
  localparam int unsigned E2M_W  = E2_W - 1;
  localparam int unsigned MT_W   = SPEED_W + TFM_W;
  localparam int unsigned DEN_W  = DAM_W + E2M_W;

  // Quotient bits kept by the divider (matches the output width)
  localparam int unsigned QW = OUT_W;

  // Saturation limits
  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== rtl/core/stick_to_wheel_rpm_mixer_core.sv =====
// ----------------------------------------------------------------------------
// Stick to wheel rpm mixer
// Skid-steer mixer: throttle and steering sticks in, signed wheel targets out.
// ----------------------------------------------------------------------------
// Takes one stick word per clock while the output is not stalled and returns
// one wheel word per word taken, in order. From input acceptance to out_valid
// a word passes three front stages (classify, factor products, numerator
// products), one divider range-check stage, 16 divider stages that retire one
// quotient bit each for both the outer and the inner wheel lane, and the
// output register that applies sign and saturation. A one-word skid buffer
// sits at the input so in_ready is a flop and never follows out_ready in the
// same cycle; a stalled output freezes the whole pipe. Outputs are in
// 1/2^SPEED_FRAC_BITS rpm, truncated toward zero and saturated to 16 bits.
// Write configuration only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_to_wheel_rpm_mixer_core #(
  parameter int unsigned SPEED_FRAC_BITS = stwrm_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [stwrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stwrm_pkg::CFG_W-1:0]         cfg_data,
  // stick words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [stwrm_pkg::STICK_W-1:0]       throttle_stick,
  input  logic [stwrm_pkg::STICK_W-1:0]       steer_stick,
  // wheel words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [stwrm_pkg::OUT_W-1:0]  right_speed,
  output logic signed [stwrm_pkg::OUT_W-1:0]  left_speed
);

  import stwrm_pkg::*;

  // Numerator width: |m * tf| * |d2| scaled by the fraction bits
  localparam int unsigned NW = MT_W + D2M_W + SPEED_FRAC_BITS;
  // Partial remainder width: numerator or divisor shifted by the quotient span
  localparam int unsigned RW = (NW > DEN_W + QW) ? NW : DEN_W + QW;

  // Output routing: which lane (0 outer, 1 inner) and whether it is negated
  typedef struct packed {
    logic r_b;
    logic r_neg;
    logic l_b;
    logic l_neg;
  } route_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [STICK_W-1:0] dead_low;
  logic [STICK_W-1:0] dead_high;
  logic [STICK_W-1:0] stick_min;
  logic [STICK_W-1:0] stick_max;
  logic [SPEED_W-1:0] max_speed;
  logic               throttle_dir;
  logic               skid_dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_low     <= DEAD_LOW_RST;
      dead_high    <= DEAD_HIGH_RST;
      stick_min    <= STICK_MIN_RST;
      stick_max    <= STICK_MAX_RST;
      max_speed    <= MAX_SPEED_RST;
      throttle_dir <= 1'b0;
      skid_dir     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEAD_LOW:     dead_low     <= cfg_data[STICK_W-1:0];
        REG_DEAD_HIGH:    dead_high    <= cfg_data[STICK_W-1:0];
        REG_STICK_MIN:    stick_min    <= cfg_data[STICK_W-1:0];
        REG_STICK_MAX:    stick_max    <= cfg_data[STICK_W-1:0];
        REG_MAX_SPEED:    max_speed    <= cfg_data[SPEED_W-1:0];
        REG_THROTTLE_DIR: throttle_dir <= cfg_data[0];
        REG_SKID_DIR:     skid_dir     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global advance and input skid buffer
  // --------------------------------------------------------------------------
  // The pipe moves whenever the output register is empty or being drained.
  logic adv;
  assign adv = !out_valid || out_ready;

  logic               skid_full;
  logic [STICK_W-1:0] skid_t;
  logic [STICK_W-1:0] skid_s;

  assign in_ready = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (adv) begin
      skid_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && in_ready) begin
      skid_t <= throttle_stick;
      skid_s <= steer_stick;
    end
  end

  logic               src_valid;
  logic [STICK_W-1:0] src_t;
  logic [STICK_W-1:0] src_s;

  assign src_valid = skid_full || in_valid;
  assign src_t     = skid_full ? skid_t : throttle_stick;
  assign src_s     = skid_full ? skid_s : steer_stick;

  // --------------------------------------------------------------------------
  // Stage 1: classify the sticks, build the signed factors and the routing
  // --------------------------------------------------------------------------
  // Both lanes compute sign(N) * |N| / |D|:
  //   lane A: N = 2^F * m * tf,            D = da
  //   lane B: N = 2^F * m * tf * d2f,      D = da * e2
  // Throttle only, steering only and the zero case use lane A alone; a
  // diagonal quadrant uses lane A for the outer wheel and lane B for the
  // inner one. A zero span is folded into tf = -1 with a fixed divisor.
  logic                      t_in, s_in, up, right, left, lane_b_right;
  logic signed [ARITH_W-1:0] t_x, s_x, dl_x, dh_x, mn_x, mx_x;
  logic signed [ARITH_W-1:0] span, ta, tb, sa, sb, d1, d2, e_x;
  logic signed [ARITH_W-1:0] tf, da, d2f, e2;
  route_t                    route;

  always_comb begin
    t_x  = $signed({{(ARITH_W-STICK_W){1'b0}}, src_t});
    s_x  = $signed({{(ARITH_W-STICK_W){1'b0}}, src_s});
    dl_x = $signed({{(ARITH_W-STICK_W){1'b0}}, dead_low});
    dh_x = $signed({{(ARITH_W-STICK_W){1'b0}}, dead_high});
    mn_x = $signed({{(ARITH_W-STICK_W){1'b0}}, stick_min});
    mx_x = $signed({{(ARITH_W-STICK_W){1'b0}}, stick_max});

    t_in  = (src_t <= dead_high) && (src_t >= dead_low);
    s_in  = (src_s <= dead_high) && (src_s >= dead_low);
    up    = src_t > dead_high;
    right = src_s > dead_high;
    left  = src_s < dead_low;

    span = mx_x - mn_x;
    ta   = up ? dh_x + 16'sd1 : dl_x - 16'sd1;
    tb   = up ? mx_x : mn_x;
    sa   = right ? dh_x + 16'sd1 : dl_x - 16'sd1;
    sb   = right ? mx_x : mn_x;
    d1   = tb - ta;
    d2   = sb - sa;
    e_x  = d2 + (s_x - sa);

    tf    = '0;
    da    = 16'sd1;
    d2f   = 16'sd1;
    e2    = 16'sd1;
    route = '0;
    lane_b_right = up ? right : !left;

    if (s_in && t_in) begin
      // center: all zero
    end else if (s_in) begin
      // throttle only: right follows throttle sign, left mirrors it
      tf = (span == 16'sd0) ? -16'sd1 : ((t_x - mn_x) <<< 1) - span;
      da = (span == 16'sd0) ? 16'sd1 : span;
      route.r_neg = throttle_dir;
      route.l_neg = !throttle_dir;
    end else if (t_in) begin
      // steering only: half range, both wheels equal
      tf = (span == 16'sd0) ? -16'sd1 : ((s_x - mn_x) <<< 1) - span;
      da = (span == 16'sd0) ? 16'sd2 : span <<< 1;
      route.r_neg = skid_dir;
      route.l_neg = skid_dir;
    end else begin
      // diagonal quadrant; zero throttle span leaves both lanes at zero
      if (d1 != 16'sd0) begin
        tf = t_x - ta;
        da = d1;
        if (d2 != 16'sd0) begin
          d2f = d2;
          e2  = e_x;
        end
      end
      route.r_b   = throttle_dir ^ lane_b_right;
      route.l_b   = !route.r_b;
      route.r_neg = throttle_dir ^ !up;
      route.l_neg = !route.r_neg;
    end
  end

  logic                    s1_valid;
  logic signed [TF_W-1:0]  s1_tf;
  logic signed [DA_W-1:0]  s1_da;
  logic signed [D2F_W-1:0] s1_d2f;
  logic signed [E2_W-1:0]  s1_e2;
  route_t                  s1_route;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tf    <= tf[TF_W-1:0];
      s1_da    <= da[DA_W-1:0];
      s1_d2f   <= d2f[D2F_W-1:0];
      s1_e2    <= e2[E2_W-1:0];
      s1_route <= route;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitudes, quotient signs, m * |tf| and |da| * |e2|
  // --------------------------------------------------------------------------
  logic [TF_W-1:0]  tf_ng;
  logic [DA_W-1:0]  da_ng;
  logic [D2F_W-1:0] d2_ng;
  logic [E2_W-1:0]  e2_ng;
  logic [TFM_W-1:0] tf_mag;
  logic [DAM_W-1:0] da_mag;
  logic [D2M_W-1:0] d2_mag;
  logic [E2M_W-1:0] e2_mag;
  logic [MT_W-1:0]  mt_prod;
  logic [DEN_W-1:0] den_prod;

  always_comb begin
    tf_ng  = -s1_tf;
    da_ng  = -s1_da;
    d2_ng  = -s1_d2f;
    e2_ng  = -s1_e2;
    tf_mag = s1_tf[TF_W-1]   ? tf_ng[TFM_W-1:0] : s1_tf[TFM_W-1:0];
    da_mag = s1_da[DA_W-1]   ? da_ng[DAM_W-1:0] : s1_da[DAM_W-1:0];
    d2_mag = s1_d2f[D2F_W-1] ? d2_ng[D2M_W-1:0] : s1_d2f[D2M_W-1:0];
    e2_mag = s1_e2[E2_W-1]   ? e2_ng[E2M_W-1:0] : s1_e2[E2M_W-1:0];
  end

  assign mt_prod  = MT_W'(max_speed) * MT_W'(tf_mag);
  assign den_prod = DEN_W'(da_mag) * DEN_W'(e2_mag);

  logic             s2_valid;
  logic [MT_W-1:0]  s2_mt;
  logic [DEN_W-1:0] s2_db;
  logic [DAM_W-1:0] s2_da_mag;
  logic [D2M_W-1:0] s2_d2_mag;
  logic [1:0]       s2_sgn;
  route_t           s2_route;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mt     <= mt_prod;
      s2_db     <= den_prod;
      s2_da_mag <= da_mag;
      s2_d2_mag <= d2_mag;
      s2_sgn[0] <= s1_tf[TF_W-1] ^ s1_da[DA_W-1];
      s2_sgn[1] <= s1_tf[TF_W-1] ^ s1_da[DA_W-1] ^ s1_d2f[D2F_W-1] ^ s1_e2[E2_W-1];
      s2_route  <= s1_route;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: numerators (scaled by 2^F) and divisors per lane
  // --------------------------------------------------------------------------
  logic [MT_W+D2M_W-1:0] nb_prod;
  assign nb_prod = (MT_W+D2M_W)'(s2_mt) * (MT_W+D2M_W)'(s2_d2_mag);

  logic             s3_valid;
  logic [NW-1:0]    s3_n [0:1];
  logic [DEN_W-1:0] s3_d [0:1];
  logic [1:0]       s3_sgn;
  route_t           s3_route;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_n[0]  <= NW'(s2_mt) << SPEED_FRAC_BITS;
      s3_n[1]  <= NW'(nb_prod) << SPEED_FRAC_BITS;
      s3_d[0]  <= DEN_W'(s2_da_mag);
      s3_d[1]  <= s2_db;
      s3_sgn   <= s2_sgn;
      s3_route <= s2_route;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: range check, then one restoring step per stage
  // --------------------------------------------------------------------------
  // Stage 0 flags quotients of 2^QW or more (which saturate anyway) and a
  // zero divisor with a nonzero numerator. A zero numerator gets divisor 1
  // so the steps below return zero.
  logic [RW-1:0]    dv_r     [0:QW][0:1];
  logic [DEN_W-1:0] dv_d     [0:QW][0:1];
  logic [QW-1:0]    dv_q     [0:QW][0:1];
  logic             dv_ovf   [0:QW][0:1];
  logic [1:0]       dv_sgn   [0:QW];
  route_t           dv_route [0:QW];
  logic             dv_valid [0:QW];

  for (genvar ln = 0; ln < 2; ln++) begin : g_chk
    logic n_zero;
    assign n_zero = (s3_n[ln] == '0);

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ovf[0][ln] <= !n_zero && (RW'(s3_n[ln]) >= (RW'(s3_d[ln]) << QW));
        dv_r[0][ln]   <= RW'(s3_n[ln]);
        dv_d[0][ln]   <= n_zero ? DEN_W'(1) : s3_d[ln];
        dv_q[0][ln]   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_sgn[0]   <= s3_sgn;
      dv_route[0] <= s3_route;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int unsigned BIT = QW - j;

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [RW-1:0] trial;
      logic          take;
      logic [QW-1:0] q_set;

      assign trial = RW'(dv_d[j-1][ln]) << BIT;
      assign take  = dv_r[j-1][ln] >= trial;

      always_comb begin
        q_set      = dv_q[j-1][ln];
        q_set[BIT] = take;
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_r[j][ln]   <= take ? dv_r[j-1][ln] - trial : dv_r[j-1][ln];
          dv_d[j][ln]   <= dv_d[j-1][ln];
          dv_q[j][ln]   <= q_set;
          dv_ovf[j][ln] <= dv_ovf[j-1][ln];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_sgn[j]   <= dv_sgn[j-1];
        dv_route[j] <= dv_route[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j] <= 1'b0;
      end else if (adv) begin
        dv_valid[j] <= dv_valid[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Valid chain of the front stages
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      s1_valid    <= src_valid;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      dv_valid[0] <= s3_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick lane, apply sign, saturate
  // --------------------------------------------------------------------------
  function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic ovf,
                                               input logic [QW-1:0] q);
    logic [OUT_W-1:0] nq;
    nq = -q;
    if (!neg) begin
      return (ovf || q > SAT_POS) ? SAT_POS : q;
    end
    return (ovf || q > SAT_NEG) ? SAT_NEG : nq;
  endfunction

  logic [OUT_W-1:0] r_word, l_word;
  logic             r_ln, l_ln;

  always_comb begin
    r_ln   = dv_route[QW].r_b;
    l_ln   = dv_route[QW].l_b;
    r_word = sat_out(dv_route[QW].r_neg ^ dv_sgn[QW][r_ln], dv_ovf[QW][r_ln],
                     dv_q[QW][r_ln]);
    l_word = sat_out(dv_route[QW].l_neg ^ dv_sgn[QW][l_ln], dv_ovf[QW][l_ln],
                     dv_q[QW][l_ln]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      right_speed <= $signed(r_word);
      left_speed  <= $signed(l_word);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stwrm_checker.sv =====
// ----------------------------------------------------------------------------
// Stick mixer checker
// Port-level checks on the handshake and the input skid buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stick_to_wheel_rpm_mixer_core_defines.svh"

module stwrm_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [stwrm_pkg::OUT_W-1:0] right_speed,
  input wire logic signed [stwrm_pkg::OUT_W-1:0] left_speed
);

  import stwrm_pkg::*;

  // stalled output word holds
  `STWRM_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(right_speed) && $stable(left_speed))

  // skid fills only when a word arrives against a stalled output
  `STWRM_ASSERT_NOW(a_skid_fill, clk, rst, $fell(in_ready), $past(out_valid && !out_ready && in_valid))

  // a full skid means the output register is holding a word
  `STWRM_ASSERT_NOW(a_skid_out, clk, rst, !in_ready, out_valid)

  // skid drains on the first output pop
  `STWRM_ASSERT_NXT(a_skid_drain, clk, rst, !in_ready && out_ready, in_ready)

endmodule

bind stick_to_wheel_rpm_mixer_core stwrm_checker u_stwrm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .right_speed (right_speed),
  .left_speed  (left_speed)
);

`default_nettype wire
